FILE: sv/bffa_pkg.sv
package bffa_pkg;

  // Map geometry
  localparam int NUM_FRAMES = 256;
  localparam int ID_BITS    = 8;
  localparam int FRAME_BITS = $clog2(NUM_FRAMES);
  localparam int CNT_BITS   = FRAME_BITS + 1;

  // Field widths fixed by the interface
  localparam int SIZE_BITS  = 11;
  localparam int TOTAL_BITS = 16;

  localparam logic [CNT_BITS-1:0]   FRAMES_MAX = CNT_BITS'(NUM_FRAMES);
  localparam logic [TOTAL_BITS-1:0] SAT16      = '1;

  // Request function codes
  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    STAT_ALLOC    = 2'd0,
    STAT_NOMEM    = 2'd1,
    STAT_EXTFRAG  = 2'd2,
    STAT_RELEASED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_PICK,
    ST_FILL,
    ST_DONE
  } state_t;

  // Write side of the owner map
  typedef struct packed {
    logic                  wr_en;
    logic                  clr_en;
    logic [FRAME_BITS-1:0] addr;
    logic [ID_BITS-1:0]    owner;
  } map_wr_t;

  // One frame presented to the run tracker
  typedef struct packed {
    logic                  step;
    logic                  free;
    logic [FRAME_BITS-1:0] idx;
  } scan_in_t;

  // Best run found so far
  typedef struct packed {
    logic                  found;
    logic [FRAME_BITS-1:0] best_start;
  } scan_res_t;

endpackage

FILE: sv/bffa_map.sv
module bffa_map
  import bffa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  clear_all,
  input  map_wr_t               wr,
  input  logic [FRAME_BITS-1:0] rd_addr,
  output logic [ID_BITS-1:0]    rd_owner
);

  logic [ID_BITS-1:0]    mem [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] vld;
  logic [ID_BITS-1:0]    rd_data;
  logic                  rd_vld;

  // Owner storage: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr.wr_en) begin
      mem[wr.addr] <= wr.owner;
    end
    rd_data <= mem[rd_addr];
    rd_vld  <= vld[rd_addr];
  end

  // Entry valid bits; an invalid entry reads as free
  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      vld <= '0;
    end else begin
      if (wr.wr_en) begin
        vld[wr.addr] <= 1'b1;
      end
      if (wr.clr_en) begin
        vld[wr.addr] <= 1'b0;
      end
    end
  end

  assign rd_owner = rd_vld ? rd_data : '0;

endmodule

FILE: sv/bffa_scan.sv
module bffa_scan
  import bffa_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                clear,
  input  scan_in_t            scan_in,
  input  logic [CNT_BITS-1:0] need,
  output scan_res_t           res
);

  logic [CNT_BITS-1:0]   run_len;
  logic [FRAME_BITS-1:0] run_start;
  logic [CNT_BITS-1:0]   best_len;
  logic                  better;

  // Compare: run long enough and strictly shorter than the best so far
  assign better = (run_len >= need) && (!res.found || (run_len < best_len));

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      run_len   <= '0;
      res.found <= 1'b0;
    end else if (scan_in.step) begin
      if (scan_in.free) begin
        if (run_len == '0) begin
          run_start <= scan_in.idx;
        end
        run_len <= run_len + 1'b1;
      end else begin
        if (better) begin
          res.found      <= 1'b1;
          res.best_start <= run_start;
          best_len       <= run_len;
        end
        run_len <= '0;
      end
    end
  end

endmodule

FILE: sv/best_fit_frame_allocator_unit.sv
// Best-fit contiguous frame allocator.
// Request channel (req_valid/req_stall): func, owner_id, frame_count and
// size_kb. func allocate places frame_count frames at the start of the
// smallest free run that fits (lowest start on a tie); func release frees
// every frame of owner_id. Response channel (rsp_valid/rsp_stall) returns one
// transfer per request: status, start_frame, frames_moved, free_frames and
// the saturating waste and reject totals.
// Configuration channel (cfg_valid/cfg_ready/cfg_data) sets total_frames,
// clamps it to the map depth and frees the whole map; it is taken only while
// no request is in flight.
// A reject or a zero-frame allocate goes straight to the response register; a
// release scans the owner map and drains; an allocate scans, drains, picks a
// run and, unless that is a fragmentation reject, fills it. The scan walks
// the single read port of the owner map one frame per cycle, and the fill
// pass writes one frame per cycle. One request is held at a time; the next
// request transfer can follow in the cycle after the response is loaded.
// Reset (rst, synchronous) frees every frame, sets total_frames to the map
// depth and clears the totals. A stalled response holds in its register; the
// next request may be taken meanwhile but its result waits for that slot.
module best_fit_frame_allocator_unit
  import bffa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CNT_BITS-1:0]   cfg_data,
  // request
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic                  func,
  input  logic [ID_BITS-1:0]    owner_id,
  input  logic [CNT_BITS-1:0]   frame_count,
  input  logic [SIZE_BITS-1:0]  size_kb,
  // response
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output logic [1:0]            status,
  output logic [FRAME_BITS-1:0] start_frame,
  output logic [CNT_BITS-1:0]   frames_moved,
  output logic [CNT_BITS-1:0]   free_frames,
  output logic [TOTAL_BITS-1:0] waste_total_kb,
  output logic [TOTAL_BITS-1:0] ext_rejects,
  output logic [TOTAL_BITS-1:0] mem_rejects
);

  state_t state, state_next;

  // Architectural state
  logic [CNT_BITS-1:0]   total_frames;
  logic [CNT_BITS-1:0]   free_count;
  logic [TOTAL_BITS-1:0] waste_sum;
  logic [TOTAL_BITS-1:0] ext_cnt;
  logic [TOTAL_BITS-1:0] mem_cnt;

  // Request held for the duration of the operation
  logic                  op_func;
  logic [ID_BITS-1:0]    op_owner;
  logic [CNT_BITS-1:0]   op_need;
  logic [SIZE_BITS-1:0]  op_size;
  status_t               op_status;

  // Scan walk and the read pipeline stage beside it
  logic [CNT_BITS-1:0]   idx;
  logic                  p_step;
  logic                  p_end;
  logic [FRAME_BITS-1:0] p_idx;
  logic [CNT_BITS-1:0]   rel_moved;

  // Fill pass
  logic [FRAME_BITS-1:0] fill_addr;
  logic [CNT_BITS-1:0]   fill_left;

  logic                  req_fire;
  logic                  cfg_fire;
  logic                  rsp_load;
  logic                  req_reject;
  logic                  scan_clear;
  logic [FRAME_BITS-1:0] rd_addr;
  logic [ID_BITS-1:0]    rd_owner;
  map_wr_t               map_wr;
  scan_in_t              scan_in;
  scan_res_t             scan_res;

  // Completion arithmetic
  logic                  alloc_ok;
  logic [SIZE_BITS-1:0]  need_kb;
  logic [SIZE_BITS-1:0]  waste_add;
  logic [TOTAL_BITS:0]   waste_wide;
  logic [CNT_BITS:0]     free_rel;
  logic [CNT_BITS-1:0]   free_next;
  logic [CNT_BITS-1:0]   moved_next;
  logic [CNT_BITS-1:0]   cfg_total;

  bffa_map u_map (
    .clk       (clk),
    .rst       (rst),
    .clear_all (cfg_fire),
    .wr        (map_wr),
    .rd_addr   (rd_addr),
    .rd_owner  (rd_owner)
  );

  bffa_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .clear   (scan_clear),
    .scan_in (scan_in),
    .need    (op_need),
    .res     (scan_res)
  );

  assign req_fire   = req_valid && !req_stall;
  assign cfg_fire   = cfg_valid && cfg_ready;
  assign rsp_load   = (state == ST_DONE) && (!rsp_valid || !rsp_stall);
  assign req_reject = (owner_id == '0) || (free_count < frame_count);
  assign cfg_total  = (cfg_data > FRAMES_MAX) ? FRAMES_MAX : cfg_data;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_fire) begin
          priority if (func == FUNC_RELEASE) begin
            state_next = (owner_id == '0) ? ST_DONE : ST_SCAN;
          end else if (req_reject || (frame_count == '0)) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (idx == total_frames) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = (op_func == FUNC_RELEASE) ? ST_DONE : ST_PICK;
      end
      ST_PICK: begin
        state_next = scan_res.found ? ST_FILL : ST_DONE;
      end
      ST_FILL: begin
        if (fill_left == CNT_BITS'(1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (rsp_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    req_stall     = (state != ST_IDLE) || cfg_valid;
    cfg_ready     = (state == ST_IDLE);
    scan_clear    = req_fire;
    rd_addr       = idx[FRAME_BITS-1:0];
    map_wr.wr_en  = (state == ST_FILL);
    map_wr.clr_en = p_step && !p_end && (op_func == FUNC_RELEASE) && (rd_owner == op_owner);
    map_wr.addr   = (state == ST_FILL) ? fill_addr : p_idx;
    map_wr.owner  = op_owner;
    scan_in.step  = p_step && (op_func == FUNC_ALLOC);
    scan_in.free  = !p_end && (rd_owner == '0);
    scan_in.idx   = p_idx;
  end

  // Waste, free count and moved count at completion
  always_comb begin
    alloc_ok   = (op_status == STAT_ALLOC) && (op_func == FUNC_ALLOC) && (op_need != '0);
    need_kb    = {op_need, 2'b00};
    waste_add  = '0;
    if (alloc_ok && (op_size[1:0] != 2'b00) && (need_kb > op_size)) begin
      waste_add = need_kb - op_size;
    end
    waste_wide = {1'b0, waste_sum} + (TOTAL_BITS + 1)'(waste_add);
    free_rel   = {1'b0, free_count} + {1'b0, rel_moved};
    free_next  = free_count;
    moved_next = '0;
    if (op_func == FUNC_RELEASE) begin
      free_next  = (free_rel > {1'b0, total_frames}) ? total_frames : free_rel[CNT_BITS-1:0];
      moved_next = rel_moved;
    end else if (alloc_ok) begin
      free_next  = free_count - op_need;
      moved_next = op_need;
    end
  end

  // Control and architectural registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      total_frames <= FRAMES_MAX;
      free_count   <= FRAMES_MAX;
      waste_sum    <= '0;
      ext_cnt      <= '0;
      mem_cnt      <= '0;
      p_step       <= 1'b0;
      rsp_valid    <= 1'b0;
    end else begin
      state  <= state_next;
      p_step <= (state == ST_SCAN);
      if (cfg_fire) begin
        total_frames <= cfg_total;
        free_count   <= cfg_total;
      end
      if (rsp_load) begin
        rsp_valid  <= 1'b1;
        free_count <= free_next;
        waste_sum  <= waste_wide[TOTAL_BITS] ? SAT16 : waste_wide[TOTAL_BITS-1:0];
        if ((op_status == STAT_NOMEM) && (mem_cnt != SAT16)) begin
          mem_cnt <= mem_cnt + 1'b1;
        end
        if ((op_status == STAT_EXTFRAG) && (ext_cnt != SAT16)) begin
          ext_cnt <= ext_cnt + 1'b1;
        end
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Operation registers and response payload
  always_ff @(posedge clk) begin
    p_end <= (idx == total_frames);
    p_idx <= idx[FRAME_BITS-1:0];
    if (req_fire) begin
      op_func   <= func;
      op_owner  <= owner_id;
      op_need   <= frame_count;
      op_size   <= size_kb;
      idx       <= '0;
      rel_moved <= '0;
      priority if (func == FUNC_RELEASE) begin
        op_status <= STAT_RELEASED;
      end else if (req_reject) begin
        op_status <= STAT_NOMEM;
      end else begin
        op_status <= STAT_ALLOC;
      end
    end
    if (state == ST_SCAN) begin
      idx <= idx + 1'b1;
    end
    if (map_wr.clr_en) begin
      rel_moved <= rel_moved + 1'b1;
    end
    if (state == ST_PICK) begin
      if (scan_res.found) begin
        fill_addr <= scan_res.best_start;
        fill_left <= op_need;
      end else begin
        op_status <= STAT_EXTFRAG;
      end
    end
    if (state == ST_FILL) begin
      fill_addr <= fill_addr + 1'b1;
      fill_left <= fill_left - 1'b1;
    end
    if (rsp_load) begin
      status       <= op_status;
      start_frame  <= alloc_ok ? scan_res.best_start : '0;
      frames_moved <= moved_next;
      free_frames  <= free_next;
    end
  end

  // Totals are shown as held after the response that updated them
  assign waste_total_kb = waste_sum;
  assign ext_rejects    = ext_cnt;
  assign mem_rejects    = mem_cnt;

endmodule
